// ===== hdl/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse-set registry package
// Shared widths, function codes, payload structs and controller types.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int HANDLE_W            = 10;
   localparam int COUNT_W             = 11;
   localparam int DEFAULT_MAX_HANDLES = 1024;

   localparam logic [1:0] FN_CREATE  = 2'd0;
   localparam logic [1:0] FN_DESTROY = 2'd1;
   localparam logic [1:0] FN_QUERY   = 2'd2;
   localparam logic [1:0] FN_CLEAR   = 2'd3;

   typedef struct packed {
      logic [1:0]          func;
      logic [HANDLE_W-1:0] handle_in;
   } ssr_req_type;

   typedef struct packed {
      logic                success;
      logic [HANDLE_W-1:0] handle_out;
      logic [HANDLE_W-1:0] slot;
      logic                moved;
      logic [COUNT_W-1:0]  live_count;
   } ssr_rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ssr_state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ssr_cmd_type;

endpackage

// ===== hdl/ssr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sparse-set registry controller
// Two-state sequencer: capture a request, then commit it in the datapath.
// ----------------------------------------------------------------------------
module ssr_ctrl
   import ssr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output ssr_cmd_type cmd
);

   ssr_state_type state_ff;
   ssr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      busy        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_EXEC: begin
            cmd.commit = 1'b1;
            busy       = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== hdl/ssr_dp.sv =====
// ----------------------------------------------------------------------------
// Sparse-set registry datapath
// Alive map, sparse-to-dense table and packed list memories, plus counters.
// ----------------------------------------------------------------------------
module ssr_dp
   import ssr_pkg::*;
#(
   parameter int MAX_HANDLES = DEFAULT_MAX_HANDLES
)(
   input  logic        clock,
   input  logic        reset,
   input  ssr_cmd_type cmd,
   input  ssr_req_type req_data,
   output logic        rsp_valid,
   output ssr_rsp_type rsp_data
);

   localparam int HW = $clog2(MAX_HANDLES);
   localparam int CW = $clog2(MAX_HANDLES + 1);
   localparam int XW = (CW > HANDLE_W) ? CW : HANDLE_W;

   logic             alive_mem [MAX_HANDLES];
   logic [HW-1:0]    dense_mem [MAX_HANDLES];
   logic [HW-1:0]    list_mem  [MAX_HANDLES];

   ssr_req_type      req_ff;
   logic [CW-1:0]    next_ff, next_in;
   logic [CW-1:0]    live_ff, live_in;
   // handles below the epoch base were killed by a clear
   logic [CW-1:0]    base_ff, base_in;
   logic             alive_rd_ff;
   logic [HW-1:0]    dense_rd_ff;
   logic [HW-1:0]    list_rd_ff;
   logic             rsp_valid_ff;
   ssr_rsp_type      rsp_ff, rsp_in;

   logic             alive_we, dense_we, list_we;
   logic [HW-1:0]    alive_wa, dense_wa, list_wa;
   logic             alive_wd;
   logic [HW-1:0]    dense_wd, list_wd;
   logic [XW-1:0]    h_wide;
   logic             hit;
   logic [CW-1:0]    tail;

   // issue reads every cycle; data is used the cycle after capture
   always_ff @(posedge clock) begin
      alive_rd_ff <= alive_mem[HW'(req_data.handle_in)];
      dense_rd_ff <= dense_mem[HW'(req_data.handle_in)];
      list_rd_ff  <= list_mem[HW'(live_ff - CW'(1))];
      if (alive_we) begin
         alive_mem[alive_wa] <= alive_wd;
      end
      if (dense_we) begin
         dense_mem[dense_wa] <= dense_wd;
      end
      if (list_we) begin
         list_mem[list_wa] <= list_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff      <= '0;
         live_ff      <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         next_ff      <= next_in;
         live_ff      <= live_in;
         base_ff      <= base_in;
         rsp_valid_ff <= cmd.commit;
      end
   end

   assign h_wide = XW'(req_ff.handle_in);
   assign hit    = (h_wide < XW'(next_ff)) && (h_wide >= XW'(base_ff)) && alive_rd_ff;
   assign tail   = live_ff - CW'(1);

   always_comb begin
      next_in  = next_ff;
      live_in  = live_ff;
      base_in  = base_ff;
      alive_we = 1'b0;
      alive_wa = HW'(req_ff.handle_in);
      alive_wd = 1'b0;
      dense_we = 1'b0;
      dense_wa = list_rd_ff;
      dense_wd = dense_rd_ff;
      list_we  = 1'b0;
      list_wa  = dense_rd_ff;
      list_wd  = list_rd_ff;
      rsp_in   = '0;
      if (cmd.commit) begin
         case (req_ff.func)
            FN_CREATE: begin
               if (next_ff < CW'(MAX_HANDLES) && live_ff < CW'(MAX_HANDLES)) begin
                  alive_we           = 1'b1;
                  alive_wa           = HW'(next_ff);
                  alive_wd           = 1'b1;
                  dense_we           = 1'b1;
                  dense_wa           = HW'(next_ff);
                  dense_wd           = HW'(live_ff);
                  list_we            = 1'b1;
                  list_wa            = HW'(live_ff);
                  list_wd            = HW'(next_ff);
                  next_in            = next_ff + CW'(1);
                  live_in            = live_ff + CW'(1);
                  rsp_in.success     = 1'b1;
                  rsp_in.handle_out  = HANDLE_W'(next_ff);
                  rsp_in.slot        = HANDLE_W'(live_ff);
               end
            end
            FN_DESTROY: begin
               if (hit) begin
                  // swap-remove: last entry fills the vacated slot
                  alive_we       = 1'b1;
                  list_we        = 1'b1;
                  live_in        = tail;
                  rsp_in.success = 1'b1;
                  rsp_in.slot    = HANDLE_W'(dense_rd_ff);
                  if (CW'(dense_rd_ff) < tail) begin
                     dense_we          = 1'b1;
                     rsp_in.handle_out = HANDLE_W'(list_rd_ff);
                     rsp_in.moved      = 1'b1;
                  end
               end
            end
            FN_QUERY: begin
               rsp_in.success = hit;
            end
            FN_CLEAR: begin
               base_in = next_ff;
               live_in = '0;
            end
            default: begin
               rsp_in = '0;
            end
         endcase
         rsp_in.live_count = COUNT_W'(live_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_live_le_span: assert property (@(posedge clock) disable iff (reset)
      live_ff <= (next_ff - base_ff))
      else $error("live count exceeds handles issued since last clear");

   a_next_bound: assert property (@(posedge clock) disable iff (reset)
      next_ff <= CW'(MAX_HANDLES))
      else $error("handle counter beyond capacity");

   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.commit))
      else $error("response without a committed request");

   a_moved_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.moved) |-> rsp_ff.success)
      else $error("move reported on a failed destroy");

endmodule

// ===== hdl/sparse_set_entity_registry.sv =====
// ----------------------------------------------------------------------------
// Sparse-set entity registry
// Issues never-reused handles and keeps them packed in a dense list.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data (func, handle_in) and raise start. The
//   request transfers on a rising edge where start is high and busy is low.
//   func selects create, destroy (swap-remove), query alive or clear all.
//   Response channel: rsp_valid pulses for one cycle with rsp_data; it cannot
//   be held off, so the receiver must take it in that cycle.
//   Sequence: the memory reads register on the request edge and the commit
//   edge then registers the response, so rsp_valid is high in the cycle
//   after the commit. busy is high for one cycle while each request
//   commits, so a new request is not taken until the last one has
//   committed, for every function; the read-then-write pass over the
//   memories sets this.
//   Clear moves an epoch base up to the handle counter and takes no sweep.
//   Reset (synchronous, active high) empties the registry and rewinds the
//   handle counter; no memory initialization pass is needed.
// ----------------------------------------------------------------------------
module sparse_set_entity_registry
   import ssr_pkg::*;
#(
   parameter int MAX_HANDLES = DEFAULT_MAX_HANDLES
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ssr_req_type req_data,
   output logic        rsp_valid,
   output ssr_rsp_type rsp_data
);

   ssr_cmd_type cmd;

   ssr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   ssr_dp #(
      .MAX_HANDLES (MAX_HANDLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/tb_sparse_set_entity_registry.sv =====
// ----------------------------------------------------------------------------
// Sparse-set entity registry testbench
// Runs a short table of directed requests and then three phases of random
// requests: mixed traffic, a create-heavy run that uses up the handle space,
// and traffic after that point. Each response is checked field by field
// against its directed table entry or a software copy of the registry.
// ----------------------------------------------------------------------------
module tb_sparse_set_entity_registry
   import ssr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_IDS      = DEFAULT_MAX_HANDLES;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;
   localparam int MIXED_ITEMS  = 200;
   localparam int LATE_ITEMS   = 100;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      ssr_req_type req;
      logic        typed;
      ssr_rsp_type rsp;
   } stim_row_type;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   ssr_req_type req_data = '0;
   logic        busy;
   logic        rsp_valid;
   ssr_rsp_type rsp_data;

   // software copy of the registry
   bit          handle_alive [MAX_IDS];
   int          dense_slot   [MAX_IDS];
   int          live_list    [MAX_IDS];
   int          next_id    = 0;
   int          live_total = 0;

   ssr_rsp_type  expected_rsps [$];
   stim_row_type directed_rows [$];
   int           fail_count = 0;
   int           burst_left = 0;

   sparse_set_entity_registry DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Apply one request to the software registry and return its response.
   function automatic ssr_rsp_type registry_apply(ssr_req_type req);
      ssr_rsp_type rsp;
      int          h;
      int          freed;
      int          last;
      rsp = '0;
      h   = int'(req.handle_in);
      case (req.func)
         FN_CREATE: begin
            if (next_id < MAX_IDS && live_total < MAX_IDS) begin
               handle_alive[next_id] = 1'b1;
               dense_slot[next_id]   = live_total;
               live_list[live_total] = next_id;
               rsp.success    = 1'b1;
               rsp.handle_out = HANDLE_W'(next_id);
               rsp.slot       = HANDLE_W'(live_total);
               next_id++;
               live_total++;
            end
         end
         FN_DESTROY: begin
            if (h < next_id && handle_alive[h] && live_total > 0) begin
               freed = dense_slot[h];
               last  = live_list[live_total - 1];
               live_list[freed] = last;
               live_total--;
               // swap the tail entry into the hole unless the hole is the tail
               if (freed < live_total) begin
                  dense_slot[last] = freed;
                  rsp.handle_out   = HANDLE_W'(last);
                  rsp.moved        = 1'b1;
               end
               handle_alive[h] = 1'b0;
               rsp.slot        = HANDLE_W'(freed);
               rsp.success     = 1'b1;
            end
         end
         FN_QUERY: begin
            rsp.success = (h < next_id) && handle_alive[h];
         end
         default: begin
            for (int i = 0; i < live_total; i++)
               handle_alive[live_list[i]] = 1'b0;
            live_total = 0;
         end
      endcase
      rsp.live_count = COUNT_W'(live_total);
      return rsp;
   endfunction

   function automatic void add_row(logic [1:0] func, int handle, bit typed, bit ok,
                                   int hout, int slot, bit moved, int count);
      stim_row_type row;
      row.req.func       = func;
      row.req.handle_in  = HANDLE_W'(handle);
      row.typed          = typed;
      row.rsp.success    = ok;
      row.rsp.handle_out = HANDLE_W'(hout);
      row.rsp.slot       = HANDLE_W'(slot);
      row.rsp.moved      = moved;
      row.rsp.live_count = COUNT_W'(count);
      directed_rows.push_back(row);
   endfunction

   // Pick a request; destroy mostly aims at live handles, query half the time.
   function automatic ssr_req_type random_request(int create_pct, int destroy_pct,
                                                  int query_pct);
      ssr_req_type req;
      int          r;
      int          pick;
      r             = $urandom_range(0, 99);
      req.handle_in = HANDLE_W'($urandom);
      if (r < create_pct) begin
         req.func = FN_CREATE;
      end else if (r < create_pct + destroy_pct) begin
         req.func = FN_DESTROY;
         if (live_total > 0 && $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 3) == 0)
               pick = live_total - 1;
            else
               pick = $urandom_range(0, live_total - 1);
            req.handle_in = HANDLE_W'(live_list[pick]);
         end
      end else if (r < create_pct + destroy_pct + query_pct) begin
         req.func = FN_QUERY;
         if (live_total > 0 && $urandom_range(0, 1) != 0)
            req.handle_in = HANDLE_W'(live_list[$urandom_range(0, live_total - 1)]);
      end else begin
         req.func = FN_CLEAR;
      end
      return req;
   endfunction

   // Hold the request until it transfers, record the expected response,
   // then idle between bursts.
   task automatic issue(input ssr_req_type req, input bit typed,
                        input ssr_rsp_type typed_rsp);
      ssr_rsp_type predicted;
      int          gap;
      req_data <= req;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      predicted = registry_apply(req);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
   endtask

   initial begin : stimulus
      ssr_req_type req;
      int          drain;
      int          guard;

      //       func        handle typed ok hout slot mv live
      add_row(FN_QUERY,   0,    1,    0, 0,   0,   0,  0);
      add_row(FN_DESTROY, 0,    1,    0, 0,   0,   0,  0);
      add_row(FN_DESTROY, 1023, 1,    0, 0,   0,   0,  0);
      add_row(FN_CLEAR,   0,    1,    0, 0,   0,   0,  0);
      add_row(FN_CREATE,  1023, 1,    1, 0,   0,   0,  1);
      add_row(FN_CREATE,  0,    1,    1, 1,   1,   0,  2);
      add_row(FN_CREATE,  0,    1,    1, 2,   2,   0,  3);
      add_row(FN_CREATE,  0,    1,    1, 3,   3,   0,  4);
      add_row(FN_QUERY,   2,    1,    1, 0,   0,   0,  4);
      add_row(FN_QUERY,   1023, 1,    0, 0,   0,   0,  4);
      add_row(FN_QUERY,   4,    1,    0, 0,   0,   0,  4);
      add_row(FN_DESTROY, 1,    1,    1, 3,   1,   1,  3);
      add_row(FN_DESTROY, 1,    1,    0, 0,   0,   0,  3);
      add_row(FN_DESTROY, 3,    0,    0, 0,   0,   0,  0);
      add_row(FN_DESTROY, 2,    0,    0, 0,   0,   0,  0);
      add_row(FN_CREATE,  0,    0,    0, 0,   0,   0,  0);
      add_row(FN_CLEAR,   1023, 1,    0, 0,   0,   0,  0);
      add_row(FN_QUERY,   0,    1,    0, 0,   0,   0,  0);
      add_row(FN_DESTROY, 4,    1,    0, 0,   0,   0,  0);
      // counter is not rewound by clear
      add_row(FN_CREATE,  0,    1,    1, 5,   0,   0,  1);
      add_row(FN_CREATE,  0,    0,    0, 0,   0,   0,  0);
      add_row(FN_DESTROY, 5,    0,    0, 0,   0,   0,  0);
      add_row(FN_QUERY,   6,    0,    0, 0,   0,   0,  0);
      add_row(FN_DESTROY, 6,    1,    1, 0,   0,   0,  0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      for (int n = 0; n < MIXED_ITEMS; n++) begin
         req = random_request(45, 32, 20);
         issue(req, 1'b0, '0);
      end

      // use up the handle space
      guard = 0;
      while (next_id < MAX_IDS && guard < 4000) begin
         req = random_request(90, 5, 4);
         issue(req, 1'b0, '0);
         guard++;
      end

      for (int n = 0; n < LATE_ITEMS; n++) begin
         req = random_request(25, 40, 30);
         issue(req, 1'b0, '0);
      end

      start <= 1'b0;
      drain = 0;
      while (expected_rsps.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin : rsp_check
      ssr_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: response with none pending: %p", $realtime, rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.success    !== want.success    ||
                rsp_data.handle_out !== want.handle_out ||
                rsp_data.slot       !== want.slot       ||
                rsp_data.moved      !== want.moved      ||
                rsp_data.live_count !== want.live_count) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: mismatch exp ok=%0d h=%0d slot=%0d mv=%0d live=%0d",
                           $realtime, want.success, want.handle_out, want.slot,
                           want.moved, want.live_count,
                           " got ok=%0d h=%0d slot=%0d mv=%0d live=%0d",
                           rsp_data.success, rsp_data.handle_out, rsp_data.slot,
                           rsp_data.moved, rsp_data.live_count);
            end
         end
      end
   end

endmodule

// ===== filelist.f =====
hdl/ssr_pkg.sv
hdl/ssr_ctrl.sv
hdl/ssr_dp.sv
hdl/sparse_set_entity_registry.sv
bench/tb_sparse_set_entity_registry.sv
